// ----- rtl/fbd_pkg.sv -----
package fbd_pkg;

  // default screen geometry
  localparam int ScreenWidth  = 128;
  localparam int ScreenHeight = 64;

  // coordinate field width of the command word
  localparam int CoordW = 10;

  // command codes
  typedef enum logic [2:0] {
    ModePixel   = 3'd0,
    ModeLine    = 3'd1,
    ModeFill    = 3'd2,
    ModeOutline = 3'd3,
    ModeSquare  = 3'd4,
    ModeClear   = 3'd5,
    ModeRead    = 3'd6
  } fbd_mode_e;

  // one byte update request to the pixel unit
  typedef struct packed {
    logic       go;
    logic       lit;
    logic [7:0] mask;
  } fbd_op_t;

  // pixel unit status
  typedef struct packed {
    logic ready;
    logic done;
  } fbd_sts_t;

  // number of 8-row pages
  function automatic int page_count(int height);
    return (height + 7) >> 3;
  endfunction

  // bits for a column index
  function automatic int col_w(int width);
    return (width > 1) ? $clog2(width) : 1;
  endfunction

  // bits for a page index
  function automatic int page_w(int height);
    return (page_count(height) > 1) ? $clog2(page_count(height)) : 1;
  endfunction

endpackage

// ----- rtl/fbd_ram.sv -----
module fbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fbd_plot.sv -----
module fbd_plot #(
  parameter int SCREEN_WIDTH  = fbd_pkg::ScreenWidth,
  parameter int SCREEN_HEIGHT = fbd_pkg::ScreenHeight
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  fbd_pkg::fbd_op_t                          op_i,
  input  logic [fbd_pkg::col_w(SCREEN_WIDTH)-1:0]   col_i,
  input  logic [fbd_pkg::page_w(SCREEN_HEIGHT)-1:0] page_i,
  output fbd_pkg::fbd_sts_t                         sts_o,
  output logic [7:0]                                rd_byte_o
);

  localparam int Pages = fbd_pkg::page_count(SCREEN_HEIGHT);
  localparam int Depth = SCREEN_WIDTH * Pages;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic {
    PIdle,
    PMod
  } plot_state_e;

  plot_state_e state_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    mask_q;
  logic          lit_q;

  logic [AW-1:0] addr_c;
  logic [7:0]    rdata;
  logic [7:0]    wdata;
  logic          we;

  // byte address: page times screen width plus column
  assign addr_c = AW'(page_i) * AW'(SCREEN_WIDTH) + AW'(col_i);

  // read in idle, merge and write back in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PIdle;
      addr_q  <= '0;
      mask_q  <= '0;
      lit_q   <= 1'b0;
    end else begin
      unique case (state_q)
        PIdle: begin
          if (op_i.go) begin
            addr_q  <= addr_c;
            mask_q  <= op_i.mask;
            lit_q   <= op_i.lit;
            state_q <= PMod;
          end
        end
        PMod: begin
          state_q <= PIdle;
        end
      endcase
    end
  end

  // merge the masked bits
  assign we    = (state_q == PMod);
  assign wdata = lit_q ? (rdata | mask_q) : (rdata & ~mask_q);

  fbd_ram #(
    .Width (8),
    .Depth (Depth),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .raddr_i (addr_c),
    .rdata_o (rdata)
  );

  assign sts_o.ready = (state_q == PIdle);
  assign sts_o.done  = (state_q == PMod);
  assign rd_byte_o   = rdata;

endmodule

// ----- rtl/mono_framebuffer_draw_engine_unit.sv -----
// channel | direction | handshake               | word
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | in_valid_i/in_ready_o   | mode_i x_a_i y_a_i x_b_i y_b_i color_i
// out     | output    | out_valid_o/out_ready_i | read_byte_o
//
// work: each framebuffer byte is read, then merged and written back; fill, square, outline
//   and clear walk every column of every page spanned, a line one byte per on-screen
//   pixel, stepping over off-screen pixels without a write
// reset: clearing pass over every column of every page, ready low
// stalls: one command at a time; a finished command posts its result from StDone and waits
//   there only while the result register is still full and not taken
module mono_framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = fbd_pkg::ScreenWidth,
  parameter int SCREEN_HEIGHT = fbd_pkg::ScreenHeight
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        mode_i,
  input  logic signed [9:0] x_a_i,
  input  logic signed [9:0] y_a_i,
  input  logic signed [9:0] x_b_i,
  input  logic signed [9:0] y_b_i,
  input  logic              color_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_byte_o
);

  localparam int Pages = fbd_pkg::page_count(SCREEN_HEIGHT);
  localparam int ColW  = fbd_pkg::col_w(SCREEN_WIDTH);
  localparam int PageW = fbd_pkg::page_w(SCREEN_HEIGHT);
  localparam int XBW   = ColW + 1;
  localparam int YBW   = PageW + 4;
  localparam int CW    = fbd_pkg::CoordW;

  localparam logic signed [12:0] WS = 13'(SCREEN_WIDTH);
  localparam logic signed [12:0] HS = 13'(SCREEN_HEIGHT);
  localparam logic signed [12:0] PS = 13'(Pages);

  typedef enum logic [3:0] {
    StIdle,
    StRLoad,
    StRSet,
    StRChk,
    StRFill,
    StSqChk,
    StSqFit,
    StLSet,
    StLErr,
    StLWalk,
    StRead,
    StReadW,
    StDone
  } seq_state_e;

  seq_state_e          state_q, state_d;
  fbd_pkg::fbd_mode_e  mode_q, mode_d;
  logic                lit_q, lit_d;
  logic                clr_q, clr_d;
  logic                init_q, init_d;
  logic [1:0]          part_q, part_d;
  logic signed [CW-1:0] xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;

  // rectangle walk
  logic signed [11:0]  org_x_q, org_x_d, org_y_q, org_y_d;
  logic signed [11:0]  ext_x_q, ext_x_d, ext_y_q, ext_y_d;
  logic [XBW-1:0]      xlo_q, xlo_d, xhi_q, xhi_d;
  logic [YBW-1:0]      ylo_q, ylo_d, yhi_q, yhi_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [PageW-1:0]    page_q, page_d;
  logic signed [11:0]  sz_q, sz_d;

  // line walk
  logic signed [CW-1:0] walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic signed [11:0]  dx_q, dx_d, dy_q, dy_d;
  logic                sx_q, sx_d, sy_q, sy_d;
  logic signed [12:0]  err_q, err_d;

  // result
  logic [7:0]          res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          read_byte_q, read_byte_d;

  // pixel unit interface
  fbd_pkg::fbd_op_t    op;
  fbd_pkg::fbd_sts_t   sts;
  logic [ColW-1:0]     op_col;
  logic [PageW-1:0]    op_page;
  logic [7:0]          rd_byte;

  // helpers
  logic                accept;
  logic                rect_end;
  logic [7:0]          fill_mask;
  logic [YBW-1:0]      yv;
  logic [YBW-1:0]      y_end;
  logic [PageW-1:0]    first_page, last_page;
  logic [ColW-1:0]     col_last;
  logic signed [12:0]  ox, oy, ex, ey;
  logic [XBW-1:0]      xlo_c, xhi_c;
  logic [YBW-1:0]      ylo_c, yhi_c;
  logic signed [13:0]  e2;
  logic                step_x, step_y, on_screen, at_end;
  logic signed [12:0]  sq_sum, sq_room;

  assign accept = in_valid_i && in_ready_o;

  // row mask of the current page inside the rectangle
  always_comb begin
    yv = '0;
    for (int b = 0; b < 8; b++) begin
      yv           = {1'b0, page_q, 3'(b)};
      fill_mask[b] = (yv >= ylo_q) && (yv < yhi_q);
    end
  end

  assign y_end      = yhi_q - 1'b1;
  assign first_page = ylo_q[PageW+2:3];
  assign last_page  = clr_q ? PageW'(Pages - 1) : y_end[PageW+2:3];
  assign col_last   = ColW'(xhi_q - 1'b1);

  // clamp the rectangle to the screen
  assign ox = 13'(org_x_q);
  assign oy = 13'(org_y_q);
  assign ex = ox + 13'(ext_x_q);
  assign ey = oy + 13'(ext_y_q);
  assign xlo_c = (ox < 0) ? '0 : (ox > WS) ? XBW'(SCREEN_WIDTH) : XBW'(ox);
  assign xhi_c = (ex < 0) ? '0 : (ex > WS) ? XBW'(SCREEN_WIDTH) : XBW'(ex);
  assign ylo_c = (oy < 0) ? '0 : (oy > HS) ? YBW'(SCREEN_HEIGHT) : YBW'(oy);
  assign yhi_c = (ey < 0) ? '0 : (ey > HS) ? YBW'(SCREEN_HEIGHT) : YBW'(ey);

  // bresenham step decision
  assign e2        = $signed({err_q, 1'b0});
  assign step_x    = (e2 >= 14'(dy_q));
  assign step_y    = (e2 <= 14'(dx_q));
  assign on_screen = (walk_x_q >= 0) && (13'(walk_x_q) < WS)
                  && (walk_y_q >= 0) && (13'(walk_y_q) < HS);
  assign at_end    = (walk_x_q == xb_q) && (walk_y_q == yb_q);

  // square fit against the bottom edge
  assign sq_sum  = 13'(ya_q) + 13'(sz_q);
  assign sq_room = HS - 13'(ya_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    lit_d       = lit_q;
    clr_d       = clr_q;
    init_d      = init_q;
    part_d      = part_q;
    xa_d        = xa_q;
    ya_d        = ya_q;
    xb_d        = xb_q;
    yb_d        = yb_q;
    org_x_d     = org_x_q;
    org_y_d     = org_y_q;
    ext_x_d     = ext_x_q;
    ext_y_d     = ext_y_q;
    xlo_d       = xlo_q;
    xhi_d       = xhi_q;
    ylo_d       = ylo_q;
    yhi_d       = yhi_q;
    col_d       = col_q;
    page_d      = page_q;
    sz_d        = sz_q;
    walk_x_d    = walk_x_q;
    walk_y_d    = walk_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    err_d       = err_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    read_byte_d = read_byte_q;
    rect_end    = 1'b0;

    op.go    = 1'b0;
    op.lit   = clr_q ? 1'b0 : lit_q;
    op.mask  = clr_q ? 8'hFF : fill_mask;
    op_col   = col_q;
    op_page  = page_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          mode_d = fbd_pkg::fbd_mode_e'(mode_i);
          xa_d   = x_a_i;
          ya_d   = y_a_i;
          xb_d   = x_b_i;
          yb_d   = y_b_i;
          lit_d  = 1'b1;
          clr_d  = 1'b0;
          part_d = '0;
          res_d  = '0;
          unique case (fbd_pkg::fbd_mode_e'(mode_i))
            fbd_pkg::ModePixel: begin
              lit_d   = color_i;
              state_d = StRLoad;
            end
            fbd_pkg::ModeLine: begin
              state_d = StLSet;
            end
            fbd_pkg::ModeFill, fbd_pkg::ModeOutline: begin
              state_d = StRLoad;
            end
            fbd_pkg::ModeSquare: begin
              lit_d   = color_i;
              state_d = StSqChk;
            end
            fbd_pkg::ModeClear: begin
              clr_d   = 1'b1;
              xhi_d   = XBW'(SCREEN_WIDTH);
              ylo_d   = '0;
              col_d   = '0;
              page_d  = '0;
              state_d = StRFill;
            end
            fbd_pkg::ModeRead: begin
              state_d = StRead;
            end
            default: begin
              state_d = StDone;
            end
          endcase
        end
      end

      // pick origin and extent of the next rectangle
      StRLoad: begin
        org_x_d = 12'(xa_q);
        org_y_d = 12'(ya_q);
        ext_x_d = 12'(xb_q);
        ext_y_d = 12'(yb_q);
        if (mode_q == fbd_pkg::ModePixel) begin
          ext_x_d = 12'sd1;
          ext_y_d = 12'sd1;
        end else if (mode_q == fbd_pkg::ModeOutline) begin
          unique case (part_q)
            2'd0: begin
              ext_y_d = 12'sd1;
            end
            2'd1: begin
              org_y_d = 12'(ya_q) + 12'(yb_q) - 12'sd1;
              ext_y_d = 12'sd1;
            end
            2'd2: begin
              ext_x_d = 12'sd1;
            end
            2'd3: begin
              org_x_d = 12'(xa_q) + 12'(xb_q) - 12'sd1;
              ext_x_d = 12'sd1;
            end
          endcase
        end
        state_d = StRSet;
      end

      StRSet: begin
        xlo_d   = xlo_c;
        xhi_d   = xhi_c;
        ylo_d   = ylo_c;
        yhi_d   = yhi_c;
        state_d = StRChk;
      end

      StRChk: begin
        if ((xlo_q >= xhi_q) || (ylo_q >= yhi_q)) begin
          rect_end = 1'b1;
        end else begin
          col_d   = ColW'(xlo_q);
          page_d  = first_page;
          state_d = StRFill;
        end
      end

      // one byte per column and page
      StRFill: begin
        if (sts.ready) begin
          op.go = 1'b1;
          if (page_q == last_page) begin
            page_d = first_page;
            if (col_q == col_last) begin
              rect_end = 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end else begin
            page_d = page_q + 1'b1;
          end
        end
      end

      // square: reject, then fit against the right edge
      StSqChk: begin
        if ((13'(xa_q) >= WS) || (13'(ya_q) >= HS) || (xb_q <= 0)) begin
          state_d = StDone;
        end else begin
          if ((13'(xa_q) + 13'(xb_q)) > WS) begin
            sz_d = 12'(WS - 13'(xa_q));
          end else begin
            sz_d = 12'(xb_q);
          end
          state_d = StSqFit;
        end
      end

      StSqFit: begin
        org_x_d = 12'(xa_q);
        org_y_d = 12'(ya_q);
        ext_x_d = (sq_sum > HS) ? 12'(sq_room) : sz_q;
        ext_y_d = (sq_sum > HS) ? 12'(sq_room) : sz_q;
        state_d = StRSet;
      end

      // line setup
      StLSet: begin
        dx_d     = (xb_q > xa_q) ? 12'(xb_q) - 12'(xa_q) : 12'(xa_q) - 12'(xb_q);
        dy_d     = (yb_q > ya_q) ? 12'(ya_q) - 12'(yb_q) : 12'(yb_q) - 12'(ya_q);
        sx_d     = !(xa_q < xb_q);
        sy_d     = !(ya_q < yb_q);
        walk_x_d = xa_q;
        walk_y_d = ya_q;
        state_d  = StLErr;
      end

      StLErr: begin
        err_d   = 13'(dx_q) + 13'(dy_q);
        state_d = StLWalk;
      end

      // plot the current point, then step
      StLWalk: begin
        op.lit  = 1'b1;
        op.mask = 8'(1) << walk_y_q[2:0];
        op_col  = walk_x_q[ColW-1:0];
        op_page = walk_y_q[PageW+2:3];
        if (sts.ready || !on_screen) begin
          op.go = on_screen;
          if (at_end) begin
            state_d = StDone;
          end else begin
            err_d = err_q + (step_x ? 13'(dy_q) : 13'sd0)
                          + (step_y ? 13'(dx_q) : 13'sd0);
            if (step_x) begin
              walk_x_d = sx_q ? walk_x_q - 1'b1 : walk_x_q + 1'b1;
            end
            if (step_y) begin
              walk_y_d = sy_q ? walk_y_q - 1'b1 : walk_y_q + 1'b1;
            end
          end
        end
      end

      // byte readback, written back unchanged
      StRead: begin
        op.lit  = 1'b0;
        op.mask = '0;
        op_col  = xa_q[ColW-1:0];
        op_page = ya_q[PageW-1:0];
        if ((xa_q >= 0) && (13'(xa_q) < WS) && (ya_q >= 0) && (13'(ya_q) < PS)) begin
          if (sts.ready) begin
            op.go   = 1'b1;
            state_d = StReadW;
          end
        end else begin
          state_d = StDone;
        end
      end

      StReadW: begin
        if (sts.done) begin
          res_d   = rd_byte;
          state_d = StDone;
        end
      end

      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          read_byte_d = res_q;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // rectangle finished: next outline side, end of reset clear, or result
    if (rect_end) begin
      if ((mode_q == fbd_pkg::ModeOutline) && !clr_q && (part_q != 2'd3)) begin
        part_d  = part_q + 1'b1;
        state_d = StRLoad;
      end else if (init_q) begin
        init_d  = 1'b0;
        clr_d   = 1'b0;
        state_d = StIdle;
      end else begin
        state_d = StDone;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRFill;
      mode_q      <= fbd_pkg::ModeClear;
      lit_q       <= 1'b0;
      clr_q       <= 1'b1;
      init_q      <= 1'b1;
      part_q      <= '0;
      xa_q        <= '0;
      ya_q        <= '0;
      xb_q        <= '0;
      yb_q        <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      ext_x_q     <= '0;
      ext_y_q     <= '0;
      xlo_q       <= '0;
      xhi_q       <= XBW'(SCREEN_WIDTH);
      ylo_q       <= '0;
      yhi_q       <= '0;
      col_q       <= '0;
      page_q      <= '0;
      sz_q        <= '0;
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sx_q        <= 1'b0;
      sy_q        <= 1'b0;
      err_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      read_byte_q <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      lit_q       <= lit_d;
      clr_q       <= clr_d;
      init_q      <= init_d;
      part_q      <= part_d;
      xa_q        <= xa_d;
      ya_q        <= ya_d;
      xb_q        <= xb_d;
      yb_q        <= yb_d;
      org_x_q     <= org_x_d;
      org_y_q     <= org_y_d;
      ext_x_q     <= ext_x_d;
      ext_y_q     <= ext_y_d;
      xlo_q       <= xlo_d;
      xhi_q       <= xhi_d;
      ylo_q       <= ylo_d;
      yhi_q       <= yhi_d;
      col_q       <= col_d;
      page_q      <= page_d;
      sz_q        <= sz_d;
      walk_x_q    <= walk_x_d;
      walk_y_q    <= walk_y_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      err_q       <= err_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      read_byte_q <= read_byte_d;
    end
  end

  fbd_plot #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_plot (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .col_i     (op_col),
    .page_i    (op_page),
    .sts_o     (sts),
    .rd_byte_o (rd_byte)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign read_byte_o = read_byte_q;

endmodule
